/* rtl/rmv_pkg.sv */
// ----------------------------------------------------------------------------
// Running mean / variance package
// Field widths, derived widths, action codes and the divider command type.
// ----------------------------------------------------------------------------
`default_nettype none

package rmv_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int COUNT_BITS    = 32;
   localparam int FRACTION_BITS = 16;

   localparam int MEAN_BITS = SAMPLE_BITS + FRACTION_BITS;
   localparam int VAR_BITS  = 2 * SAMPLE_BITS + FRACTION_BITS;
   // difference of two mean-width values, and the product of two of them
   localparam int DIFF_BITS = MEAN_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;

   localparam int DIV_STEP_BITS = $clog2(VAR_BITS + 1);
   localparam int MUL_STEP_BITS = $clog2(DIFF_BITS + 1);

   localparam logic [DIV_STEP_BITS-1:0] MEAN_DIV_STEPS = DIV_STEP_BITS'(DIFF_BITS);
   localparam logic [DIV_STEP_BITS-1:0] VAR_DIV_STEPS  = DIV_STEP_BITS'(VAR_BITS);
   localparam logic [MUL_STEP_BITS-1:0] MUL_STEPS      = MUL_STEP_BITS'(DIFF_BITS);

   localparam logic ACTION_ADD   = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   typedef struct packed {
      logic                     start;
      logic [DIV_STEP_BITS-1:0] steps;
   } div_cmd_type;

endpackage

`default_nettype wire

/* rtl/running_mean_variance.sv */
// ----------------------------------------------------------------------------
// Running mean and variance
// Welford update of a population mean and variance in fixed point, built
// from a shared bit-serial divider and a bit-serial multiplier.
// ----------------------------------------------------------------------------
// Sequence: an add transaction runs the mean division (33 steps), the
//    product (33 steps) and the variance division (48 steps) before it
//    reaches the result register; a clear goes straight to the publish state.
// Flow: one transaction at a time; an add is paced by the serial divider
//    that both divisions share and the serial multiplier; a stalled
//    response holds the next transaction back.
// Reset: synchronous; count, mean and variance return to zero, no result.
// ----------------------------------------------------------------------------
`default_nettype none

module running_mean_variance (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_action,
   input  wire logic signed [rmv_pkg::SAMPLE_BITS-1:0] req_sample,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [rmv_pkg::COUNT_BITS-1:0]        rsp_count_out,
   output logic signed [rmv_pkg::MEAN_BITS-1:0]       rsp_mean_out,
   output logic      [rmv_pkg::VAR_BITS-1:0]          rsp_variance_out
);

   localparam int MB = rmv_pkg::MEAN_BITS;
   localparam int DB = rmv_pkg::DIFF_BITS;
   localparam int VB = rmv_pkg::VAR_BITS;
   localparam int CB = rmv_pkg::COUNT_BITS;
   localparam int FB = rmv_pkg::FRACTION_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN_DIV,
      ST_MEAN_FIX,
      ST_MUL,
      ST_VAR_DIV,
      ST_PUBLISH
   } state_type;

   state_type            state_ff, state_in;
   logic [CB-1:0]        count_ff, count_in;
   logic [MB-1:0]        mean_ff, mean_in;
   logic [VB-1:0]        var_ff, var_in;
   logic [MB-1:0]        x_ff, x_in;
   logic [MB-1:0]        m_ff, m_in;
   logic                 d_neg_ff, d_neg_in;
   logic [DB-1:0]        d_mag_ff, d_mag_in;
   logic                 t_ge_ff, t_ge_in;
   rmv_pkg::div_cmd_type div_cmd_ff, div_cmd_in;
   logic [VB-1:0]        div_dividend_ff, div_dividend_in;
   logic                 mul_start_ff, mul_start_in;
   logic [DB-1:0]        mul_a_ff, mul_a_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]        rsp_count_ff, rsp_count_in;
   logic [MB-1:0]        rsp_mean_ff, rsp_mean_in;
   logic [VB-1:0]        rsp_var_ff, rsp_var_in;

   logic [VB-1:0]        div_quotient;
   logic [CB-1:0]        div_remainder;
   logic                 div_done;
   logic [rmv_pkg::PROD_BITS-1:0] mul_product;
   logic                 mul_done;

   logic [MB-1:0]        x_new;
   logic [DB-1:0]        d_new;
   logic [DB:0]          q_signed;
   logic [DB:0]          m_wide;
   logic                 rem_nz;
   logic [DB:0]          m_fixed;
   logic [DB-1:0]        xm_diff;
   logic [VB-1:0]        t_val;
   logic [VB:0]          tv_diff;
   logic [VB-1:0]        vt_diff;
   logic                 out_free;

   rmv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd_ff),
      .dividend  (div_dividend_ff),
      .divisor   (count_ff),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .done      (div_done)
   );

   rmv_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a       (mul_a_ff),
      .b       (d_mag_ff),
      .product (mul_product),
      .done    (mul_done)
   );

   always_comb begin
      x_new = {req_sample, {FB{1'b0}}};
      d_new = {x_new[MB-1], x_new} - {mean_ff[MB-1], mean_ff};

      // signed quotient, then nudge toward zero where the remainder's sign
      // disagrees with the sign of the new mean
      q_signed = d_neg_ff ? ({(DB+1){1'b0}} - {1'b0, div_quotient[DB-1:0]})
                          : {1'b0, div_quotient[DB-1:0]};
      m_wide   = {{2{mean_ff[MB-1]}}, mean_ff} + q_signed;
      rem_nz   = |div_remainder;
      m_fixed  = m_wide;
      if (!m_wide[DB] && (|m_wide) && d_neg_ff && rem_nz) begin
         m_fixed = m_wide - 1'b1;
      end else if (m_wide[DB] && !d_neg_ff && rem_nz) begin
         m_fixed = m_wide + 1'b1;
      end

      xm_diff = {x_ff[MB-1], x_ff} - {m_ff[MB-1], m_ff};

      // scale the product down and clamp it to the variance width
      if (|mul_product[rmv_pkg::PROD_BITS-1:VB+FB]) begin
         t_val = '1;
      end else begin
         t_val = mul_product[VB+FB-1:FB];
      end
      tv_diff = {1'b0, t_val} - {1'b0, var_ff};
      vt_diff = var_ff - t_val;

      out_free = !rsp_valid_ff || !rsp_stall;

      state_in        = state_ff;
      count_in        = count_ff;
      mean_in         = mean_ff;
      var_in          = var_ff;
      x_in            = x_ff;
      m_in            = m_ff;
      d_neg_in        = d_neg_ff;
      d_mag_in        = d_mag_ff;
      t_ge_in         = t_ge_ff;
      div_cmd_in      = '0;
      div_dividend_in = div_dividend_ff;
      mul_start_in    = 1'b0;
      mul_a_in        = mul_a_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_count_in    = rsp_count_ff;
      rsp_mean_in     = rsp_mean_ff;
      rsp_var_in      = rsp_var_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == rmv_pkg::ACTION_CLEAR) begin
                  count_in = '0;
                  mean_in  = '0;
                  var_in   = '0;
                  state_in = ST_PUBLISH;
               end else begin
                  count_in = (&count_ff) ? count_ff : count_ff + 1'b1;
                  x_in     = x_new;
                  d_neg_in = d_new[DB-1];
                  d_mag_in = d_new[DB-1] ? ({DB{1'b0}} - d_new) : d_new;
                  div_dividend_in  = {d_mag_in, {(VB-DB){1'b0}}};
                  div_cmd_in.start = 1'b1;
                  div_cmd_in.steps = rmv_pkg::MEAN_DIV_STEPS;
                  state_in = ST_MEAN_DIV;
               end
            end
         end
         ST_MEAN_DIV: begin
            if (div_done) begin
               m_in     = m_fixed[MB-1:0];
               state_in = ST_MEAN_FIX;
            end
         end
         ST_MEAN_FIX: begin
            mean_in      = m_ff;
            mul_a_in     = xm_diff[DB-1] ? ({DB{1'b0}} - xm_diff) : xm_diff;
            mul_start_in = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               t_ge_in          = !tv_diff[VB];
               div_dividend_in  = tv_diff[VB] ? vt_diff : tv_diff[VB-1:0];
               div_cmd_in.start = 1'b1;
               div_cmd_in.steps = rmv_pkg::VAR_DIV_STEPS;
               state_in         = ST_VAR_DIV;
            end
         end
         ST_VAR_DIV: begin
            if (div_done) begin
               if (t_ge_ff) begin
                  var_in = var_ff + div_quotient;
               end else begin
                  var_in = var_ff - div_quotient - {{(VB-1){1'b0}}, rem_nz};
               end
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            // hold until the result register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_mean_in  = mean_ff;
               rsp_var_in   = var_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mean_ff      <= '0;
         var_ff       <= '0;
         div_cmd_ff   <= '0;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         var_ff       <= var_in;
         div_cmd_ff   <= div_cmd_in;
         mul_start_ff <= mul_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff            <= x_in;
      m_ff            <= m_in;
      d_neg_ff        <= d_neg_in;
      d_mag_ff        <= d_mag_in;
      t_ge_ff         <= t_ge_in;
      div_dividend_ff <= div_dividend_in;
      mul_a_ff        <= mul_a_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_mean_ff     <= rsp_mean_in;
      rsp_var_ff      <= rsp_var_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_count_out    = rsp_count_ff;
   assign rsp_mean_out     = rsp_mean_ff;
   assign rsp_variance_out = rsp_var_ff;

endmodule

`default_nettype wire

/* rtl/rmv_div.sv */
// ----------------------------------------------------------------------------
// Running mean / variance divider
// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned; the command gives the number of quotient bits to produce.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rmv_pkg::div_cmd_type                cmd,
   input  wire logic [rmv_pkg::VAR_BITS-1:0]        dividend,
   input  wire logic [rmv_pkg::COUNT_BITS-1:0]      divisor,
   output logic      [rmv_pkg::VAR_BITS-1:0]        quotient,
   output logic      [rmv_pkg::COUNT_BITS-1:0]      remainder,
   output logic                                     done
);

   logic [rmv_pkg::COUNT_BITS-1:0]    rem_ff, rem_in;
   logic [rmv_pkg::VAR_BITS-1:0]      quo_ff, quo_in;
   logic [rmv_pkg::COUNT_BITS-1:0]    divisor_ff, divisor_in;
   logic [rmv_pkg::DIV_STEP_BITS-1:0] step_ff, step_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;

   logic [rmv_pkg::COUNT_BITS:0]      trial;
   logic [rmv_pkg::COUNT_BITS:0]      diff;

   always_comb begin
      trial = {rem_ff, quo_ff[rmv_pkg::VAR_BITS-1]};
      diff  = trial - {1'b0, divisor_ff};

      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;

      if (cmd.start) begin
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
         step_in    = cmd.steps;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         // partial remainder stays below twice the divisor, so the sign bit
         // of the difference tells whether the divisor fits
         if (!diff[rmv_pkg::COUNT_BITS]) begin
            rem_in = diff[rmv_pkg::COUNT_BITS-1:0];
            quo_in = {quo_ff[rmv_pkg::VAR_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[rmv_pkg::COUNT_BITS-1:0];
            quo_in = {quo_ff[rmv_pkg::VAR_BITS-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == rmv_pkg::DIV_STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

/* rtl/rmv_mul.sv */
// ----------------------------------------------------------------------------
// Running mean / variance multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, for two unsigned
// difference magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_mul (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [rmv_pkg::DIFF_BITS-1:0]     a,
   input  wire logic [rmv_pkg::DIFF_BITS-1:0]     b,
   output logic      [rmv_pkg::PROD_BITS-1:0]     product,
   output logic                                   done
);

   logic [rmv_pkg::DIFF_BITS:0]       acc_ff, acc_in;
   logic [rmv_pkg::DIFF_BITS-1:0]     mlr_ff, mlr_in;
   logic [rmv_pkg::DIFF_BITS-1:0]     mcand_ff, mcand_in;
   logic [rmv_pkg::MUL_STEP_BITS-1:0] step_ff, step_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;

   logic [rmv_pkg::DIFF_BITS:0]       sum;

   always_comb begin
      sum = acc_ff + (mlr_ff[0] ? {1'b0, mcand_ff} : '0);

      acc_in   = acc_ff;
      mlr_in   = mlr_ff;
      mcand_in = mcand_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (start) begin
         acc_in   = '0;
         mlr_in   = b;
         mcand_in = a;
         step_in  = rmv_pkg::MUL_STEPS;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // shift the low product bit into the multiplier register
         acc_in  = {1'b0, sum[rmv_pkg::DIFF_BITS:1]};
         mlr_in  = {sum[0], mlr_ff[rmv_pkg::DIFF_BITS-1:1]};
         step_in = step_ff - 1'b1;
         if (step_ff == rmv_pkg::MUL_STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff   <= acc_in;
      mlr_ff   <= mlr_in;
      mcand_ff <= mcand_in;
      step_ff  <= step_in;
   end

   assign product = {acc_ff[rmv_pkg::DIFF_BITS-1:0], mlr_ff};
   assign done    = done_ff;

endmodule

`default_nettype wire
